// ===== src/midpoint_odometry_integrator_macros.svh =====
// assertion macros used by the checker file
`ifndef MIDPOINT_ODOMETRY_INTEGRATOR_MACROS_SVH
`define MIDPOINT_ODOMETRY_INTEGRATOR_MACROS_SVH

// same-cycle implication
`define MOI_ASSERT_IMM(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MOI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/moi_pkg.sv =====
package moi_pkg;

    // request kinds
    localparam logic [1:0] OP_VEL  = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_POSE = 2'd2;

    // cordic datapath width, q2.30 plus headroom
    localparam int CW = 34;
    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [23:0] lin_vel;
        logic signed [23:0] ang_vel;
        logic [15:0]        elapsed;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        heading;
    } t_req;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic [15:0]        out_heading;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [23:0] out_lin_vel;
        logic signed [23:0] out_ang_vel;
    } t_rsp;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [29:0] atan_turn(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/moi_if.sv =====
interface moi_req_if;
    import moi_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface moi_rsp_if;
    import moi_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/midpoint_odometry_integrator.sv =====
// Planar dead-reckoning pose integrator with a second-order midpoint step. A velocity
// request (op 0) stores forward speed and turn rate, a pose request (op 2) overwrites
// x, y and heading; both give no response, and op 3 is ignored. A
// tick request (op 1) advances the pose by elapsed time and gives one response with
// the new pose, the heading quaternion z and w, and the speeds used. After a tick is
// taken the request side stays busy until its response is loaded into the output
// register, so a new request is not taken while a tick is still being worked:
// one iterative CORDIC register set runs twice (midpoint heading, then half of the new
// heading), one stage per cycle, and a single registered 27x27 multiplier forms
// rate*dt, speed*dt and the two 40x26 position products in halves. The response sits
// in an output register, so the next request is taken while it waits; the tick only
// stalls at its last step if the previous response has still not been taken.
// Positions are 32-bit with POS_FRAC_BITS fraction bits and saturate; heading is a
// 16-bit binary angle that wraps.
module midpoint_odometry_integrator #(
    parameter int CORDIC_STAGES = 16,
    parameter int POS_FRAC_BITS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    moi_req_if.sink   i_req,
    moi_rsp_if.source o_rsp
);
    import moi_pkg::*;

    localparam int IW         = $clog2(CORDIC_STAGES);
    localparam int TRIG_SHIFT = 58 - POS_FRAC_BITS;
    localparam int MW         = 27;      // multiplier operand width
    localparam int PW         = 2 * MW;  // product width
    localparam int AW         = 66;      // position product width
    localparam int SW         = 34;      // position sum width
    localparam logic signed [AW-1:0] RND = AW'(1) << (TRIG_SHIFT - 1);

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MULP  = 4'd1;   // rate * dt
    localparam logic [3:0] ST_MULT  = 4'd2;   // speed * dt, split rate * dt
    localparam logic [3:0] ST_CINIT = 4'd3;   // load cordic
    localparam logic [3:0] ST_CORD  = 4'd4;   // cordic iterations
    localparam logic [3:0] ST_TRIG  = 4'd5;   // round cos, sin to q.22
    localparam logic [3:0] ST_MLO   = 4'd6;   // low half of dt*speed times trig
    localparam logic [3:0] ST_MHI   = 4'd7;   // high half
    localparam logic [3:0] ST_MSUM  = 4'd8;   // combine halves
    localparam logic [3:0] ST_UPD   = 4'd9;   // add to pose, saturate
    localparam logic [3:0] ST_HEAD  = 4'd10;  // advance heading
    localparam logic [3:0] ST_QUAT  = 4'd11;  // load response

    logic [3:0] r_state;
    logic [3:0] n_state;

    // architectural state
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;
    logic [15:0]        r_heading;
    logic signed [23:0] r_speed;
    logic signed [23:0] r_rate;

    // tick working registers
    logic [15:0]          r_elapsed;
    logic signed [PW-1:0] r_prod;
    logic signed [39:0]   r_t;
    logic [31:0]          r_mid_off;
    logic [15:0]          r_step;
    logic signed [MW-1:0] r_qc;
    logic signed [MW-1:0] r_qs;
    logic signed [AW-1:0] r_acc;
    logic                 r_axis;   // 0 x, 1 y
    logic                 r_pass;   // 0 midpoint angle, 1 quaternion angle

    // cordic registers
    logic signed [CW-1:0] r_cx;
    logic signed [CW-1:0] r_cy;
    logic signed [CW-1:0] r_cz;
    logic                 r_flip;
    logic [IW-1:0]        r_iter;

    // response register
    t_rsp r_out;
    logic r_out_valid;

    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [MW-1:0] q_sel;
    logic signed [40:0]   p_mid;
    logic signed [40:0]   p_step;
    logic [31:0]          ang_mid;
    logic [31:0]          ang_half;
    logic [31:0]          ang;
    logic                 ang_flip;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] at;
    logic signed [CW-1:0] c_rnd;
    logic signed [CW-1:0] s_rnd;
    logic signed [AW-1:0] d_shift;
    logic signed [SW-1:0] pos_sum;
    logic signed [31:0]   pos_cur;
    logic                 out_free;

    function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
        logic signed [31:0] r;
        if (v > SW'(64'sd2147483647)) begin
            r = 32'sh7FFFFFFF;
        end else if (v < SW'(-64'sd2147483648)) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // round q2.30 to q1.15 half up with optional negation, saturate
    function automatic logic signed [15:0] to_q15(input logic signed [CW-1:0] v,
                                                  input logic flip);
        logic signed [CW-1:0] s;
        logic signed [CW-1:0] sh;
        logic signed [15:0]   r;
        s  = flip ? (CW'(16384) - v) : (v + CW'(16384));
        sh = s >>> 15;
        if (sh > CW'(32767)) begin
            r = 16'sh7FFF;
        end else if (sh < CW'(-32768)) begin
            r = 16'sh8000;
        end else begin
            r = sh[15:0];
        end
        return r;
    endfunction

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;
    assign out_free    = !r_out_valid || o_rsp.ready;

    // rate*dt rounding for the midpoint offset and the heading step
    assign p_mid  = 41'(signed'(r_prod[39:0])) + 41'sd16;
    assign p_step = 41'(signed'(r_prod[39:0])) + 41'sd524288;

    // cordic start angle; quadrants 1 and 2 are folded by a half turn
    assign ang_mid  = {r_heading, 16'b0} + r_mid_off;
    assign ang_half = {(r_heading > 16'd32768), r_heading, 15'b0};
    assign ang      = r_pass ? ang_half : ang_mid;
    assign ang_flip = ang[31] ^ ang[30];

    // one cordic micro-rotation
    assign sx = r_cx >>> r_iter;
    assign sy = r_cy >>> r_iter;
    assign at = signed'(CW'(atan_turn(5'(r_iter))));

    // unfold and round to q.22
    assign c_rnd = r_flip ? (CW'(128) - r_cx) : (r_cx + CW'(128));
    assign s_rnd = r_flip ? (CW'(128) - r_cy) : (r_cy + CW'(128));

    // position update
    assign q_sel   = r_axis ? r_qs : r_qc;
    assign d_shift = r_acc >>> TRIG_SHIFT;
    assign pos_cur = r_axis ? r_py : r_px;
    assign pos_sum = SW'(pos_cur) + signed'(d_shift[SW-1:0]);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_MULP: begin
                mul_a = MW'(r_rate);
                mul_b = MW'(signed'({1'b0, r_elapsed}));
            end
            ST_MULT: begin
                mul_a = MW'(r_speed);
                mul_b = MW'(signed'({1'b0, r_elapsed}));
            end
            ST_MLO: begin
                mul_a = signed'({{(MW-20){1'b0}}, r_t[19:0]});
                mul_b = q_sel;
            end
            ST_MHI: begin
                mul_a = MW'(signed'(r_t[39:20]));
                mul_b = q_sel;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req.valid && i_req.data.op == OP_TICK) begin
                    n_state = ST_MULP;
                end
            end
            ST_MULP:  n_state = ST_MULT;
            ST_MULT:  n_state = ST_CINIT;
            ST_CINIT: n_state = ST_CORD;
            ST_CORD: begin
                if (r_iter == IW'(CORDIC_STAGES - 1)) begin
                    n_state = r_pass ? ST_QUAT : ST_TRIG;
                end
            end
            ST_TRIG:  n_state = ST_MLO;
            ST_MLO:   n_state = ST_MHI;
            ST_MHI:   n_state = ST_MSUM;
            ST_MSUM:  n_state = ST_UPD;
            ST_UPD:   n_state = r_axis ? ST_HEAD : ST_MLO;
            ST_HEAD:  n_state = ST_CINIT;
            ST_QUAT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_pass      <= 1'b0;
            r_axis      <= 1'b0;
            r_iter      <= '0;
            r_px        <= '0;
            r_py        <= '0;
            r_heading   <= '0;
            r_speed     <= '0;
            r_rate      <= '0;
        end else begin
            r_state <= n_state;

            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_req.valid) begin
                        case (i_req.data.op)
                            OP_VEL: begin
                                r_speed <= i_req.data.lin_vel;
                                r_rate  <= i_req.data.ang_vel;
                            end
                            OP_POSE: begin
                                r_px      <= i_req.data.pos_x;
                                r_py      <= i_req.data.pos_y;
                                r_heading <= i_req.data.heading;
                            end
                            default: begin
                                r_pass <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_CINIT: begin
                    r_iter <= '0;
                end
                ST_CORD: begin
                    r_iter <= r_iter + 1'b1;
                end
                ST_TRIG: begin
                    r_axis <= 1'b0;
                end
                ST_UPD: begin
                    if (r_axis) begin
                        r_py <= sat32(pos_sum);
                    end else begin
                        r_px <= sat32(pos_sum);
                    end
                    r_axis <= 1'b1;
                end
                ST_HEAD: begin
                    r_heading <= r_heading + r_step;
                    r_pass    <= 1'b1;
                end
                ST_QUAT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_pass      <= 1'b0;
                    end
                end
                default: begin
                    r_iter <= r_iter;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;

        if (r_state == ST_IDLE) begin
            r_elapsed <= i_req.data.elapsed;
        end

        if (r_state == ST_MULT) begin
            r_mid_off <= p_mid[36:5];
            r_step    <= p_step[35:20];
        end

        if (r_state == ST_CINIT) begin
            if (!r_pass) begin
                r_t <= r_prod[39:0];
            end
            r_cx   <= GAIN_Q30;
            r_cy   <= '0;
            r_cz   <= CW'(signed'({ang[31] ^ ang_flip, ang[30:0]}));
            r_flip <= ang_flip;
        end

        if (r_state == ST_CORD) begin
            if (!r_cz[CW-1]) begin
                r_cx <= r_cx - sy;
                r_cy <= r_cy + sx;
                r_cz <= r_cz - at;
            end else begin
                r_cx <= r_cx + sy;
                r_cy <= r_cy - sx;
                r_cz <= r_cz + at;
            end
        end

        if (r_state == ST_TRIG) begin
            r_qc <= MW'(c_rnd >>> 8);
            r_qs <= MW'(s_rnd >>> 8);
        end

        if (r_state == ST_MHI) begin
            r_acc <= AW'(r_prod) + RND;
        end else if (r_state == ST_MSUM) begin
            r_acc <= r_acc + (AW'(r_prod) <<< 20);
        end

        if (r_state == ST_QUAT && out_free) begin
            r_out.out_x       <= r_px;
            r_out.out_y       <= r_py;
            r_out.out_heading <= r_heading;
            r_out.quat_z      <= to_q15(r_cy, r_flip);
            r_out.quat_w      <= to_q15(r_cx, r_flip);
            r_out.out_lin_vel <= r_speed;
            r_out.out_ang_vel <= r_rate;
        end
    end

endmodule

// ===== src/moi_checker.sv =====
`include "midpoint_odometry_integrator_macros.svh"

module moi_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_req_valid,
    input logic          i_req_ready,
    input moi_pkg::t_req i_req_data,
    input logic          i_rsp_valid,
    input logic          i_rsp_ready,
    input moi_pkg::t_rsp i_rsp_data
);
    import moi_pkg::*;

    // a stalled response holds
    `MOI_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_data), "response changed while stalled")

    // a tick keeps the request side busy
    `MOI_ASSERT_NXT(a_tick_busy, i_clk, i_rst_n, i_req_valid && i_req_ready && i_req_data.op == OP_TICK, !i_req_ready, "ready after tick request")

    // commands, corrections and dropped ops leave the request side ready in the next cycle
    `MOI_ASSERT_NXT(a_cmd_fast, i_clk, i_rst_n, i_req_valid && i_req_ready && i_req_data.op != OP_TICK, i_req_ready, "not ready after command")

    // a response only appears at the end of tick work
    `MOI_ASSERT_IMM(a_rsp_from_work, i_clk, i_rst_n, $rose(i_rsp_valid), !$past(i_req_ready), "response without tick work")

endmodule

bind midpoint_odometry_integrator moi_checker u_moi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_data  (i_req.data),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

// ===== tb/tb_midpoint_odometry_integrator.sv =====
module tb_midpoint_odometry_integrator;
    timeunit 1ns;
    timeprecision 1ps;

    import moi_pkg::*;

    // op 3 has no name in the package, the block drops it
    localparam logic [1:0] OP_NONE = 2'd3;

    // datapath settings matching the default build of the block
    localparam int     N_STAGES    = 16;
    localparam int     POS_FRAC    = 16;
    localparam int     TRIG_RSH    = 58 - POS_FRAC;
    localparam longint CORDIC_GAIN = 652032874;

    localparam int N_MOTION_REQS = 1550;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 120;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    moi_req_if req_if ();
    moi_rsp_if rsp_if ();

    midpoint_odometry_integrator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // rotation steps, atan(2^-i) in 2^-32 turn
    longint turn_atan [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    // predicted odometry state at the block's widths
    logic signed [31:0] odo_x;
    logic signed [31:0] odo_y;
    logic [15:0]        odo_hdg;
    logic signed [23:0] odo_speed;
    logic signed [23:0] odo_rate;

    t_req odo_requests [$];
    t_rsp pose_reports_due [$];

    int   n_total_reqs;
    int   n_requests_taken;
    int   n_reports_checked;
    int   n_mismatches;
    int   n_ticks, n_vel_cmds, n_pose_fixes, n_dropped;
    logic req_taken    = 1'b0;
    logic hold_reports = 1'b0;
    t_rsp report_want;
    t_rsp report_calc;

    // ---------------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------------

    // sin/cos of an angle in 2^-32 turn, q2.30, left half folded onto the right
    function automatic void rotate(input logic [31:0] ang, output longint c,
                                   output longint s);
        logic [31:0] a;
        bit          flip;
        longint      x, y, z, nx;
        int          i;
        a    = ang;
        flip = a[31] ^ a[30];
        if (flip) a = a + 32'h8000_0000;
        x = CORDIC_GAIN;
        y = 0;
        z = longint'($signed(a));
        for (i = 0; i < N_STAGES; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - turn_atan[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + turn_atan[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic [15:0] to_q15(input longint v);
        longint r;
        r = (v + 16384) >>> 15;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    // distance along one axis: trig cut to q.22, then scaled down to position
    function automatic longint axis_step(input longint travel, input longint trig);
        longint q;
        q = (trig + 128) >>> 8;
        return (travel * q + (64'sd1 <<< (TRIG_RSH - 1))) >>> TRIG_RSH;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // advances the predicted pose; returns 1 when the request yields a report
    function automatic bit integrate_request(input t_req r, output t_rsp o);
        longint      dt, p, travel, c, s;
        logic [63:0] u;
        logic [31:0] mid, half;
        o = '0;
        case (r.op)
            OP_VEL: begin
                odo_speed = r.lin_vel;
                odo_rate  = r.ang_vel;
                return 1'b0;
            end
            OP_POSE: begin
                odo_x   = r.pos_x;
                odo_y   = r.pos_y;
                odo_hdg = r.heading;
                return 1'b0;
            end
            OP_TICK: begin
                dt = longint'(r.elapsed);
                p  = longint'(odo_rate) * dt;
                // heading half a step ahead, 2^-32 turn
                u   = p + 16;
                mid = {odo_hdg, 16'h0000} + u[36:5];
                rotate(mid, c, s);
                travel = longint'(odo_speed) * dt;
                odo_x  = clamp32(longint'(odo_x) + axis_step(travel, c));
                odo_y  = clamp32(longint'(odo_y) + axis_step(travel, s));
                // full heading step rounded to binary angle, wraps
                u       = p + (64'sd1 <<< 19);
                odo_hdg = odo_hdg + u[35:20];
                // half heading, upper half read as negative so w stays >= 0
                half = {1'b0, odo_hdg, 15'h0000};
                if (odo_hdg > 16'd32768) half = half + 32'h8000_0000;
                rotate(half, c, s);
                o.out_x       = odo_x;
                o.out_y       = odo_y;
                o.out_heading = odo_hdg;
                o.quat_z      = to_q15(s);
                o.quat_w      = to_q15(c);
                o.out_lin_vel = odo_speed;
                o.out_ang_vel = odo_rate;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        n_mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("report %0d %s got %h want %h",
                                      n_reports_checked, name, got, want));
    endtask

    // sample both channels at the rising edge
    always @(posedge i_clk) begin
        req_taken <= req_if.valid && req_if.ready;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (pose_reports_due.size() == 0) begin
                    report_mismatch("pose report with nothing outstanding");
                end else begin
                    report_want = pose_reports_due.pop_front();
                    check_field("out_x", rsp_if.data.out_x, report_want.out_x);
                    check_field("out_y", rsp_if.data.out_y, report_want.out_y);
                    check_field("out_heading", 32'(rsp_if.data.out_heading),
                                32'(report_want.out_heading));
                    check_field("quat_z", 32'(rsp_if.data.quat_z),
                                32'(report_want.quat_z));
                    check_field("quat_w", 32'(rsp_if.data.quat_w),
                                32'(report_want.quat_w));
                    check_field("out_lin_vel", 32'(rsp_if.data.out_lin_vel),
                                32'(report_want.out_lin_vel));
                    check_field("out_ang_vel", 32'(rsp_if.data.out_ang_vel),
                                32'(report_want.out_ang_vel));
                end
                n_reports_checked++;
            end
            if (req_if.valid && req_if.ready) begin
                n_requests_taken++;
                case (req_if.data.op)
                    OP_TICK: n_ticks++;
                    OP_VEL:  n_vel_cmds++;
                    OP_POSE: n_pose_fixes++;
                    default: n_dropped++;
                endcase
                if (integrate_request(req_if.data, report_calc))
                    pose_reports_due.push_back(report_calc);
            end
        end
    end

    // ---------------------------------------------------------------------
    // driving
    // ---------------------------------------------------------------------

    // idle percentage per side, stepping through three phases of the run
    function automatic int idle_pct(input bit receiver);
        int phase;
        phase = n_requests_taken * 3 / n_total_reqs;
        case (phase)
            0:       return receiver ? 60 : 7;
            1:       return receiver ? 7 : 60;
            default: return 0;
        endcase
    endfunction

    // requests go out and ready changes at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!req_if.valid || req_taken) begin
                if (odo_requests.size() != 0 &&
                    (hold_reports || $urandom_range(99) >= idle_pct(1'b0))) begin
                    req_if.valid <= 1'b1;
                    req_if.data  <= odo_requests.pop_front();
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
            rsp_if.ready <= !hold_reports && ($urandom_range(99) >= idle_pct(1'b1));
        end
    end

    // long receiver stall so the output register and then the request side fill up
    initial begin
        wait (n_requests_taken >= HOLD_AT);
        @(posedge i_clk);
        hold_reports <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_reports <= 1'b0;
    end

    initial begin
        #8_000_000;
        $display("timeout with %0d pose reports outstanding", pose_reports_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ---------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------

    // every field random, then the used ones overwritten by the caller
    function automatic t_req scrambled(input logic [1:0] op);
        t_req r;
        r.op      = op;
        r.lin_vel = 24'($urandom);
        r.ang_vel = 24'($urandom);
        r.elapsed = 16'($urandom);
        r.pos_x   = $urandom;
        r.pos_y   = $urandom;
        r.heading = 16'($urandom);
        return r;
    endfunction

    task automatic queue_vel(input logic [23:0] lin, input logic [23:0] ang);
        t_req r;
        r         = scrambled(OP_VEL);
        r.lin_vel = lin;
        r.ang_vel = ang;
        odo_requests.push_back(r);
    endtask

    task automatic queue_tick(input logic [15:0] dt);
        t_req r;
        r         = scrambled(OP_TICK);
        r.elapsed = dt;
        odo_requests.push_back(r);
    endtask

    task automatic queue_pose(input logic [31:0] x, input logic [31:0] y,
                              input logic [15:0] h);
        t_req r;
        r         = scrambled(OP_POSE);
        r.pos_x   = x;
        r.pos_y   = y;
        r.heading = h;
        odo_requests.push_back(r);
    endtask

    function automatic int spread(input int k);
        return int'($urandom_range(0, 2 * k)) - k;
    endfunction

    initial begin
        int n_motion;
        int pick;

        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        odo_x        = '0;
        odo_y        = '0;
        odo_hdg      = '0;
        odo_speed    = '0;
        odo_rate     = '0;

        // zero elapsed straight out of reset, and a dropped op
        queue_tick(16'd0);
        odo_requests.push_back(scrambled(OP_NONE));
        // extreme speeds and rates with the longest step
        queue_vel(24'h7F_FFFF, 24'h7F_FFFF);
        queue_tick(16'hFFFF);
        queue_tick(16'd0);
        queue_vel(24'h80_0000, 24'h80_0000);
        queue_tick(16'hFFFF);
        // x runs into the positive limit
        queue_pose(32'h7FFF_FFFF, 32'h8000_0000, 16'h0000);
        queue_vel(24'h7F_FFFF, 24'h00_0000);
        queue_tick(16'hFFFF);
        // heading -90 degrees drives y into the negative limit
        queue_pose(32'h8000_0000, 32'h8000_0000, 16'hC000);
        queue_tick(16'hFFFF);
        // reverse at a half turn, x again into the positive limit
        queue_vel(24'h80_0000, 24'h00_0000);
        queue_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000);
        queue_tick(16'hFFFF);
        odo_requests.push_back(scrambled(OP_NONE));
        // quaternion around the half turn and the wrap point
        queue_vel(24'h00_0000, 24'h00_0000);
        queue_pose(32'h0, 32'h0, 16'h8000);
        queue_tick(16'd0);
        queue_pose(32'h0, 32'h0, 16'h8001);
        queue_tick(16'd0);
        queue_pose(32'h0, 32'h0, 16'hFFFF);
        queue_tick(16'd0);

        // random traffic: mostly ticks around 1 ms with commands mixed in
        n_motion = 0;
        while (n_motion < N_MOTION_REQS) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                odo_requests.push_back(scrambled(OP_NONE));
                n_motion++;
            end else if (pick < 24) begin
                if ($urandom_range(9) < 3)
                    queue_vel(24'($urandom), 24'($urandom));
                else
                    queue_vel(24'(spread(196608)), 24'(spread(131072)));
                n_motion++;
            end else if (pick < 34) begin
                if ($urandom_range(9) < 4)
                    queue_pose($urandom, $urandom, 16'($urandom));
                else
                    queue_pose(spread(6553600), spread(6553600), 16'($urandom));
                n_motion++;
            end else begin
                pick = $urandom_range(99);
                if (pick < 5)
                    queue_tick(16'd0);
                else if (pick < 20)
                    queue_tick(16'($urandom_range(0, 65535)));
                else
                    queue_tick(16'($urandom_range(800, 1300)));
                n_motion++;
            end
        end
        n_total_reqs = odo_requests.size();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (odo_requests.size() != 0 || req_if.valid) @(posedge i_clk);
        while (pose_reports_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d ticks, %0d velocity and %0d pose requests, %0d dropped ops",
                 n_ticks, n_vel_cmds, n_pose_fixes, n_dropped);
        $display("%0d pose reports checked, %0d field mismatches",
                 n_reports_checked, n_mismatches);
        if (n_mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
